/* src/acd_pkg.sv */
// ----------------------------------------------------------------------------
// Autocorrelation peak detector package
// Shared sizes, register indexes and the divider handshake types.
// ----------------------------------------------------------------------------
package acd_pkg;

   localparam int FRAME_SIZE  = 1024;
   localparam int FRAME_BITS  = $clog2(FRAME_SIZE);
   localparam int HALF_FRAME  = FRAME_SIZE / 2;
   localparam int LAG_BITS    = FRAME_BITS - 1;
   localparam int MAX_PEAKS   = 5;
   localparam int PEAK_IDX_W  = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
   localparam int PEAK_CNT_W  = $clog2(MAX_PEAKS + 1);

   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 2 * SAMPLE_W + FRAME_BITS + 1;

   localparam int RATE_W      = 18;
   localparam int FREQ_W      = 17;
   localparam int PCT_W       = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 18;

   localparam int MUL_A_W     = SUM_W + PCT_W;
   localparam int MUL_B_W     = (FRAME_BITS + 8 > SAMPLE_W) ? FRAME_BITS + 8 : SAMPLE_W;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;

   localparam int SCAN_START  = (HALF_FRAME / 8 < 1) ? 1 : HALF_FRAME / 8;
   localparam int SCAN_LAST   = HALF_FRAME - 2;
   localparam int THRESH_SCALE = FRAME_SIZE * 100;

   localparam int DIV_W       = SUM_W;
   localparam int DIVR_W      = FRAME_BITS + 1;
   localparam int DIV_CNT_W   = $clog2(DIV_W);

   localparam int OUT_FREQ_W  = 18;
   localparam int OUT_LAG_W   = 9;
   localparam int OUT_MAG_W   = 31;
   localparam int OUT_RANK_W  = 3;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 96;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FREQ    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FREQ    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 2'd3;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DIVR_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

/* src/acd_div.sv */
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module acd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  acd_pkg::div_req_type div_req,
   output acd_pkg::div_rsp_type div_rsp
);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [acd_pkg::DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [acd_pkg::DIVR_W-1:0]      rem_ff, rem_in;
   logic [acd_pkg::DIVR_W-1:0]      dvs_ff, dvs_in;
   logic [acd_pkg::DIV_W-1:0]       quo_ff, quo_in;
   logic [acd_pkg::DIVR_W:0]        rem_sh;
   logic [acd_pkg::DIVR_W:0]        rem_diff;
   logic                            fits;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      rem_sh   = {rem_ff, quo_ff[acd_pkg::DIV_W-1]};
      rem_diff = rem_sh - {1'b0, dvs_ff};
      fits     = (rem_sh >= {1'b0, dvs_ff});
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[acd_pkg::DIVR_W-1:0] : rem_sh[acd_pkg::DIVR_W-1:0];
         quo_in = {quo_ff[acd_pkg::DIV_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == acd_pkg::DIV_CNT_W'(acd_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

/* src/autocorr_feedback_peak_detector_top.sv */
// ----------------------------------------------------------------------------
// Autocorrelation peak detector
// Frame store, shared-multiplier autocorrelation, peak scan and ranking.
// ----------------------------------------------------------------------------
// Usage:
// Samples arrive on the req_ stream, one per transfer, one cycle each while
// the frame fills. The transfer that completes a 1024-sample frame starts
// the analysis and req_tready stays low until its results are loaded.
// Analysis time is set by the single multiplier fed from the two read ports
// of the frame memory: sum over lags 0..511 of (1024 - lag) multiply-
// accumulates, then the lag scan, the ranking compares and, per result, the
// two serial divisions. Results leave on the rsp_ stream, strongest first,
// rsp_tlast on the frame's final item; a frame with no peak gives one item
// with found clear. A stalled receiver holds the output register; the next
// frame fills meanwhile but its final sample waits until the register frees.
// The csr_ channel is always ready; write it only while the block is idle.
// Synchronous reset clears the fill index, the peak list and the registers
// to their defaults; the frame and lag memories need no clearing.
// ----------------------------------------------------------------------------
module autocorr_feedback_peak_detector_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [acd_pkg::REQ_DATA_W-1:0]       req_tdata,   // sample[15:0]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // found[0], frequency_hz[18:1], peak_lag[27:19], magnitude[58:28],
   // energy[89:59], rank[92:90], zero fill above
   output logic [acd_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [acd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [acd_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam logic [3:0] ST_COLLECT   = 4'd0;
   localparam logic [3:0] ST_CORR      = 4'd1;
   localparam logic [3:0] ST_BASE      = 4'd2;
   localparam logic [3:0] ST_BASEW     = 4'd3;
   localparam logic [3:0] ST_FETCH     = 4'd4;
   localparam logic [3:0] ST_FETCHW    = 4'd5;
   localparam logic [3:0] ST_TEST      = 4'd6;
   localparam logic [3:0] ST_INS       = 4'd7;
   localparam logic [3:0] ST_PLACE     = 4'd8;
   localparam logic [3:0] ST_OUT_START = 4'd9;
   localparam logic [3:0] ST_OUT_FREQ  = 4'd10;
   localparam logic [3:0] ST_OUT_MAG   = 4'd11;
   localparam logic [3:0] ST_SEND      = 4'd12;

   localparam int FB = acd_pkg::FRAME_BITS;
   localparam int LB = acd_pkg::LAG_BITS;
   localparam int SW = acd_pkg::SUM_W;
   localparam int PW = acd_pkg::PROD_W;
   localparam int CW = acd_pkg::PEAK_CNT_W;
   localparam int IW = acd_pkg::PEAK_IDX_W;

   function automatic logic [acd_pkg::DIVR_W-1:0] overlap(input logic [LB-1:0] lag);
      overlap = acd_pkg::DIVR_W'(acd_pkg::FRAME_SIZE) - acd_pkg::DIVR_W'(lag);
   endfunction

   // Memories
   logic signed [acd_pkg::SAMPLE_W-1:0] frame_mem [acd_pkg::FRAME_SIZE];
   logic signed [SW-1:0]                sums_mem  [acd_pkg::HALF_FRAME];
   logic signed [acd_pkg::SAMPLE_W-1:0] rd_a_ff, rd_b_ff;
   logic signed [SW-1:0]                sums_rd_ff;

   // Control state
   logic [3:0]                   state_ff, state_in;
   logic [FB-1:0]                write_idx_ff, write_idx_in;
   logic                         issue_on_ff, issue_on_in;
   logic                         p1_v_ff, p1_v_in, p2_v_ff, p2_v_in;
   logic [CW-1:0]                top_cnt_ff, top_cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [3:0]                   step_ff, step_in;
   logic [acd_pkg::RATE_W-1:0]   rate_ff, rate_in;
   logic [acd_pkg::FREQ_W-1:0]   min_ff, min_in, max_ff, max_in;
   logic [acd_pkg::PCT_W-1:0]    pct_ff, pct_in;
   logic [LB-1:0]                top_lag_ff [acd_pkg::MAX_PEAKS];
   logic [LB-1:0]                top_lag_in [acd_pkg::MAX_PEAKS];

   // Datapath
   logic [FB-1:0]                issue_i_ff, issue_i_in;
   logic [LB-1:0]                issue_lag_ff, issue_lag_in;
   logic                         p1_last_ff, p1_last_in, p2_last_ff, p2_last_in;
   logic [LB-1:0]                p1_lag_ff, p1_lag_in, p2_lag_ff, p2_lag_in;
   logic signed [SW-1:0]         acc_ff, acc_in, sum0_ff, sum0_in;
   logic signed [acd_pkg::MUL_A_W-1:0] base_ff, base_in;
   logic [LB-1:0]                fetch_addr_ff, fetch_addr_in;
   logic [LB-1:0]                scan_lag_ff, scan_lag_in;
   logic signed [SW-1:0]         w_p_ff, w_p_in, w_c_ff, w_c_in, w_n_ff, w_n_in;
   logic signed [PW-1:0]         hold_ff, hold_in, prod_ff;
   logic                         ok_ff, ok_in;
   logic [CW-1:0]                pos_ff, pos_in;
   logic signed [SW-1:0]         top_sum_ff [acd_pkg::MAX_PEAKS];
   logic signed [SW-1:0]         top_sum_in [acd_pkg::MAX_PEAKS];
   logic [IW-1:0]                out_k_ff, out_k_in;
   logic [acd_pkg::OUT_FREQ_W-1:0] freq_ff, freq_in;
   logic [acd_pkg::OUT_MAG_W-1:0]  mag_ff, mag_in;
   logic [acd_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Combinational helpers
   logic                         req_xfer, rsp_xfer, frame_we, issue_last;
   logic [FB-1:0]                addr_b;
   logic signed [SW-1:0]         acc_sum;
   logic signed [acd_pkg::MUL_A_W-1:0] mul_a;
   logic signed [acd_pkg::MUL_B_W-1:0] mul_b;
   logic [LB-1:0]                lag_m1, lag_p1, lag_sel;
   logic signed [SW-1:0]         sum_sel;
   logic [IW-1:0]                sel_idx;
   logic signed [PW-1:0]         rate_s;
   logic [CW-1:0]                ins_end;
   logic                         out_last, found;
   logic [acd_pkg::OUT_MAG_W-1:0] energy;
   acd_pkg::div_req_type         div_req;
   acd_pkg::div_rsp_type         div_rsp;

   acd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign addr_b     = issue_i_ff + FB'(issue_lag_ff);
   assign issue_last = (addr_b == FB'(acd_pkg::FRAME_SIZE - 1));
   assign acc_sum    = acc_ff + prod_ff[SW-1:0];
   assign lag_m1     = scan_lag_ff - LB'(1);
   assign lag_p1     = scan_lag_ff + LB'(1);
   assign rate_s     = PW'(rate_ff);
   assign sel_idx    = (state_ff == ST_OUT_START || state_ff == ST_OUT_FREQ ||
                        state_ff == ST_OUT_MAG || state_ff == ST_SEND) ?
                       out_k_ff : IW'(pos_ff - 1'b1);
   assign lag_sel    = top_lag_ff[sel_idx];
   assign sum_sel    = top_sum_ff[sel_idx];
   assign ins_end    = (top_cnt_ff < CW'(acd_pkg::MAX_PEAKS)) ?
                       top_cnt_ff : CW'(acd_pkg::MAX_PEAKS - 1);
   assign found      = (top_cnt_ff != '0);
   assign out_last   = !found || (CW'(out_k_ff) + 1'b1 == top_cnt_ff);
   assign energy     = acd_pkg::OUT_MAG_W'(sum0_ff[SW-1:FB]);

   assign req_tready = (state_ff == ST_COLLECT) &&
                       !(write_idx_ff == FB'(acd_pkg::FRAME_SIZE - 1) && rsp_valid_ff);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_valid_ff && rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      write_idx_in  = write_idx_ff;
      issue_on_in   = issue_on_ff;
      issue_i_in    = issue_i_ff;
      issue_lag_in  = issue_lag_ff;
      top_cnt_in    = top_cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      step_in       = step_ff;
      rate_in       = rate_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      pct_in        = pct_ff;
      top_lag_in    = top_lag_ff;
      top_sum_in    = top_sum_ff;
      acc_in        = acc_ff;
      sum0_in       = sum0_ff;
      base_in       = base_ff;
      fetch_addr_in = fetch_addr_ff;
      scan_lag_in   = scan_lag_ff;
      w_p_in        = w_p_ff;
      w_c_in        = w_c_ff;
      w_n_in        = w_n_ff;
      hold_in       = hold_ff;
      ok_in         = ok_ff;
      pos_in        = pos_ff;
      out_k_in      = out_k_ff;
      freq_in       = freq_ff;
      mag_in        = mag_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      frame_we      = 1'b0;
      div_req       = '0;
      mul_a         = acd_pkg::MUL_A_W'(rd_a_ff);
      mul_b         = acd_pkg::MUL_B_W'(rd_b_ff);

      if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_valid) begin
         unique case (csr_index)
            acd_pkg::CSR_SAMPLE_RATE: rate_in = csr_data;
            acd_pkg::CSR_MIN_FREQ:    min_in  = csr_data[acd_pkg::FREQ_W-1:0];
            acd_pkg::CSR_MAX_FREQ:    max_in  = csr_data[acd_pkg::FREQ_W-1:0];
            acd_pkg::CSR_THRESHOLD:   pct_in  = csr_data[acd_pkg::PCT_W-1:0];
         endcase
      end

      // Correlation pipeline: address issue, memory data, product, accumulate.
      p1_v_in    = 1'b0;
      p1_last_in = issue_last;
      p1_lag_in  = issue_lag_ff;
      if (state_ff == ST_CORR && issue_on_ff) begin
         p1_v_in = 1'b1;
         if (issue_last) begin
            issue_i_in = '0;
            if (issue_lag_ff == LB'(acd_pkg::HALF_FRAME - 1)) begin
               issue_on_in = 1'b0;
            end else begin
               issue_lag_in = issue_lag_ff + 1'b1;
            end
         end else begin
            issue_i_in = issue_i_ff + 1'b1;
         end
      end
      p2_v_in    = p1_v_ff;
      p2_last_in = p1_last_ff;
      p2_lag_in  = p1_lag_ff;
      if (p2_v_ff) begin
         if (p2_last_ff) begin
            acc_in = '0;
            if (p2_lag_ff == '0) begin
               sum0_in = acc_sum;
            end
         end else begin
            acc_in = acc_sum;
         end
      end

      unique case (state_ff)
         ST_COLLECT: begin
            if (req_xfer) begin
               frame_we     = 1'b1;
               write_idx_in = write_idx_ff + 1'b1;
               if (write_idx_ff == FB'(acd_pkg::FRAME_SIZE - 1)) begin
                  state_in     = ST_CORR;
                  issue_on_in  = 1'b1;
                  issue_i_in   = '0;
                  issue_lag_in = '0;
                  acc_in       = '0;
               end
            end
         end
         ST_CORR: begin
            if (!issue_on_ff && !p1_v_ff && !p2_v_ff) begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            mul_a    = acd_pkg::MUL_A_W'(sum0_ff);
            mul_b    = acd_pkg::MUL_B_W'(pct_ff);
            state_in = ST_BASEW;
         end
         ST_BASEW: begin
            base_in       = prod_ff[acd_pkg::MUL_A_W-1:0];
            fetch_addr_in = LB'(acd_pkg::SCAN_START - 1);
            scan_lag_in   = LB'(acd_pkg::SCAN_START);
            top_cnt_in    = '0;
            state_in      = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_FETCHW;
         end
         ST_FETCHW: begin
            // Slide the three-lag window by one entry.
            w_p_in        = w_c_ff;
            w_c_in        = w_n_ff;
            w_n_in        = sums_rd_ff;
            fetch_addr_in = fetch_addr_ff + 1'b1;
            if (fetch_addr_ff == lag_p1) begin
               state_in = ST_TEST;
               step_in  = '0;
            end else begin
               state_in = ST_FETCH;
            end
         end
         ST_TEST: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               4'd0: begin
                  ok_in = 1'b1;
                  mul_a = acd_pkg::MUL_A_W'(w_c_ff);
                  mul_b = acd_pkg::MUL_B_W'(overlap(lag_m1));
               end
               4'd1: begin
                  hold_in = prod_ff;
                  mul_a   = acd_pkg::MUL_A_W'(w_p_ff);
                  mul_b   = acd_pkg::MUL_B_W'(overlap(scan_lag_ff));
               end
               4'd2: begin
                  ok_in = ok_ff && (hold_ff > prod_ff);
                  mul_a = acd_pkg::MUL_A_W'(w_c_ff);
                  mul_b = acd_pkg::MUL_B_W'(overlap(lag_p1));
               end
               4'd3: begin
                  hold_in = prod_ff;
                  mul_a   = acd_pkg::MUL_A_W'(w_n_ff);
                  mul_b   = acd_pkg::MUL_B_W'(overlap(scan_lag_ff));
               end
               4'd4: begin
                  ok_in = ok_ff && (hold_ff > prod_ff);
                  mul_a = acd_pkg::MUL_A_W'(w_c_ff);
                  mul_b = acd_pkg::MUL_B_W'(acd_pkg::THRESH_SCALE);
               end
               4'd5: begin
                  hold_in = prod_ff;
                  mul_a   = base_ff;
                  mul_b   = acd_pkg::MUL_B_W'(overlap(scan_lag_ff));
               end
               4'd6: begin
                  ok_in = ok_ff && (hold_ff > prod_ff);
                  mul_a = acd_pkg::MUL_A_W'(min_ff);
                  mul_b = acd_pkg::MUL_B_W'(scan_lag_ff);
               end
               4'd7: begin
                  ok_in = ok_ff && (rate_s >= prod_ff);
                  mul_a = acd_pkg::MUL_A_W'(max_ff);
                  mul_b = acd_pkg::MUL_B_W'(scan_lag_ff);
               end
               default: begin
                  if (ok_ff && (rate_s <= prod_ff)) begin
                     state_in = ST_INS;
                     step_in  = '0;
                     pos_in   = top_cnt_ff;
                  end else if (scan_lag_ff == LB'(acd_pkg::SCAN_LAST)) begin
                     state_in = ST_OUT_START;
                     out_k_in = '0;
                  end else begin
                     scan_lag_in = scan_lag_ff + 1'b1;
                     state_in    = ST_FETCH;
                  end
               end
            endcase
         end
         ST_INS: begin
            // Walk up the list while the new peak is strictly stronger.
            case (step_ff)
               4'd0: begin
                  if (pos_ff == '0) begin
                     state_in = ST_PLACE;
                  end else begin
                     mul_a   = acd_pkg::MUL_A_W'(w_c_ff);
                     mul_b   = acd_pkg::MUL_B_W'(overlap(lag_sel));
                     step_in = 4'd1;
                  end
               end
               4'd1: begin
                  hold_in = prod_ff;
                  mul_a   = acd_pkg::MUL_A_W'(sum_sel);
                  mul_b   = acd_pkg::MUL_B_W'(overlap(scan_lag_ff));
                  step_in = 4'd2;
               end
               default: begin
                  if (hold_ff > prod_ff) begin
                     pos_in  = pos_ff - 1'b1;
                     step_in = '0;
                  end else begin
                     state_in = ST_PLACE;
                  end
               end
            endcase
         end
         ST_PLACE: begin
            if (pos_ff < CW'(acd_pkg::MAX_PEAKS)) begin
               for (int k = 1; k < acd_pkg::MAX_PEAKS; k++) begin
                  if (CW'(k) > pos_ff && CW'(k) <= ins_end) begin
                     top_lag_in[k] = top_lag_ff[k-1];
                     top_sum_in[k] = top_sum_ff[k-1];
                  end
               end
               for (int k = 0; k < acd_pkg::MAX_PEAKS; k++) begin
                  if (CW'(k) == pos_ff) begin
                     top_lag_in[k] = scan_lag_ff;
                     top_sum_in[k] = w_c_ff;
                  end
               end
               if (top_cnt_ff < CW'(acd_pkg::MAX_PEAKS)) begin
                  top_cnt_in = top_cnt_ff + 1'b1;
               end
            end
            if (scan_lag_ff == LB'(acd_pkg::SCAN_LAST)) begin
               state_in = ST_OUT_START;
               out_k_in = '0;
            end else begin
               scan_lag_in = scan_lag_ff + 1'b1;
               state_in    = ST_FETCH;
            end
         end
         ST_OUT_START: begin
            if (!found) begin
               state_in = ST_SEND;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = acd_pkg::DIV_W'(rate_ff);
               div_req.divisor  = acd_pkg::DIVR_W'(lag_sel);
               state_in         = ST_OUT_FREQ;
            end
         end
         ST_OUT_FREQ: begin
            if (div_rsp.done) begin
               freq_in          = div_rsp.quotient[acd_pkg::OUT_FREQ_W-1:0];
               div_req.start    = 1'b1;
               div_req.dividend = sum_sel;
               div_req.divisor  = overlap(lag_sel);
               state_in         = ST_OUT_MAG;
            end
         end
         ST_OUT_MAG: begin
            if (div_rsp.done) begin
               mag_in   = div_rsp.quotient[acd_pkg::OUT_MAG_W-1:0];
               state_in = ST_SEND;
            end
         end
         ST_SEND: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = out_last;
               rsp_data_in  = acd_pkg::RSP_DATA_W'({
                  acd_pkg::OUT_RANK_W'(out_k_ff),
                  energy,
                  found ? mag_ff : acd_pkg::OUT_MAG_W'(0),
                  found ? acd_pkg::OUT_LAG_W'(lag_sel) : acd_pkg::OUT_LAG_W'(0),
                  found ? freq_ff : acd_pkg::OUT_FREQ_W'(0),
                  found});
               if (out_last) begin
                  state_in = ST_COLLECT;
               end else begin
                  out_k_in = out_k_ff + 1'b1;
                  state_in = ST_OUT_START;
               end
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (frame_we) begin
         frame_mem[write_idx_ff] <= req_tdata;
      end
      rd_a_ff <= frame_mem[issue_i_ff];
      rd_b_ff <= frame_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (p2_v_ff && p2_last_ff) begin
         sums_mem[p2_lag_ff] <= acc_sum;
      end
      sums_rd_ff <= sums_mem[fetch_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         write_idx_ff <= '0;
         issue_on_ff  <= 1'b0;
         p1_v_ff      <= 1'b0;
         p2_v_ff      <= 1'b0;
         top_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         rate_ff      <= acd_pkg::RATE_W'(44100);
         min_ff       <= acd_pkg::FREQ_W'(100);
         max_ff       <= acd_pkg::FREQ_W'(8000);
         pct_ff       <= acd_pkg::PCT_W'(10);
         for (int k = 0; k < acd_pkg::MAX_PEAKS; k++) begin
            top_lag_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         write_idx_ff <= write_idx_in;
         issue_on_ff  <= issue_on_in;
         p1_v_ff      <= p1_v_in;
         p2_v_ff      <= p2_v_in;
         top_cnt_ff   <= top_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         rate_ff      <= rate_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         pct_ff       <= pct_in;
         top_lag_ff   <= top_lag_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_i_ff    <= issue_i_in;
      issue_lag_ff  <= issue_lag_in;
      p1_last_ff    <= p1_last_in;
      p1_lag_ff     <= p1_lag_in;
      p2_last_ff    <= p2_last_in;
      p2_lag_ff     <= p2_lag_in;
      acc_ff        <= acc_in;
      sum0_ff       <= sum0_in;
      base_ff       <= base_in;
      fetch_addr_ff <= fetch_addr_in;
      scan_lag_ff   <= scan_lag_in;
      w_p_ff        <= w_p_in;
      w_c_ff        <= w_c_in;
      w_n_ff        <= w_n_in;
      hold_ff       <= hold_in;
      ok_ff         <= ok_in;
      pos_ff        <= pos_in;
      top_sum_ff    <= top_sum_in;
      out_k_ff      <= out_k_in;
      freq_ff       <= freq_in;
      mag_ff        <= mag_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      prod_ff       <= mul_a * mul_b;
   end

   // The divider only ever finishes while the output sequencer waits on it.
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_OUT_FREQ || state_ff == ST_OUT_MAG))
      else $error("divider finished outside the output sequence");

   // The peak list never grows beyond its capacity.
   a_top_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      top_cnt_ff <= CW'(acd_pkg::MAX_PEAKS))
      else $error("peak count exceeds capacity");

   // The transfer that completes a frame starts the correlation pass.
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && write_idx_ff == FB'(acd_pkg::FRAME_SIZE - 1))
      |=> (state_ff == ST_CORR && issue_on_ff))
      else $error("full frame did not start correlation");

   // A result is loaded only when the output register is free or draining.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");

endmodule
